// ----- sv/sgrt_pkg.sv -----
// ----------------------------------------------------------------------------
// sgrt_pkg
// shared constants and types of the scatter-gather region translator
// ----------------------------------------------------------------------------
package sgrt_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_ADDR_BITS   = 48;
  localparam int MAX_RESULTS     = 16;
  localparam int SECTOR_SHIFT    = 9;
  localparam int LEN_W           = 46;
  localparam int SECT_W          = 32;
  localparam int CMD_W           = 3;
  localparam int SEG_IDX_W       = $clog2(MAX_RESULTS);
  localparam int SEG_CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_NOT_READY = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // request cursor walking down the cell row
  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] off;
    logic [LEN_W-1:0] stop;
  } token_t;

  typedef struct packed {
    logic busy;
    logic hit;
    logic done;
  } cell_stat_t;

  typedef struct packed {
    logic                 wr_en;
    logic [SEG_IDX_W-1:0] idx;
    status_t              status;
    logic                 commit;
    logic [SEG_CNT_W-1:0] cnt;
    logic                 is_write;
  } buf_ctl_t;

endpackage

// ----- sv/sgrt_cell.sv -----
// ----------------------------------------------------------------------------
// sgrt_cell
// one region entry of the table; cuts a segment off the passing cursor
// ----------------------------------------------------------------------------
module sgrt_cell #(
  parameter int ADDR_BITS = sgrt_pkg::DEF_ADDR_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [ADDR_BITS-1:0]       wr_smb,
  input  logic [sgrt_pkg::LEN_W-1:0] wr_base,
  input  logic [sgrt_pkg::LEN_W-1:0] wr_end,
  input  logic                       flush,
  input  sgrt_pkg::token_t           tok_in,
  output sgrt_pkg::token_t           tok_out,
  output sgrt_pkg::cell_stat_t       stat,
  output logic [ADDR_BITS-1:0]       seg_phys,
  output logic [sgrt_pkg::LEN_W-1:0] seg_len
);
  import sgrt_pkg::*;

  // start minus base, so one add gives the physical address
  logic [ADDR_BITS-1:0] smb_r;
  logic [LEN_W-1:0]     base_r;
  logic [LEN_W-1:0]     end_r;
  token_t               tok_r;
  logic                 hit;
  logic                 fits;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      smb_r  <= wr_smb;
      base_r <= wr_base;
      end_r  <= wr_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  always_comb begin
    hit  = tok_r.valid && (tok_r.off >= base_r) && (tok_r.off < end_r);
    fits = tok_r.stop <= end_r;
    seg_len  = fits ? (tok_r.stop - tok_r.off) : (end_r - tok_r.off);
    seg_phys = smb_r + ADDR_BITS'(tok_r.off);
    stat.busy = tok_r.valid;
    stat.hit  = hit;
    stat.done = hit && fits;
    tok_out.valid = tok_r.valid && !(hit && fits);
    tok_out.off   = hit ? end_r : tok_r.off;
    tok_out.stop  = tok_r.stop;
  end

endmodule

// ----- sv/sgrt_seg_buf.sv -----
// ----------------------------------------------------------------------------
// sgrt_seg_buf
// holds the results of one request and plays them out with the last flag
// ----------------------------------------------------------------------------
module sgrt_seg_buf #(
  parameter int ADDR_BITS = sgrt_pkg::DEF_ADDR_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sgrt_pkg::buf_ctl_t         ctl,
  input  logic [ADDR_BITS-1:0]       wr_phys,
  input  logic [sgrt_pkg::LEN_W-1:0] wr_len,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic [ADDR_BITS-1:0]       out_phys_addr,
  output logic [sgrt_pkg::LEN_W-1:0] out_seg_length,
  output logic                       out_is_write,
  output logic                       out_last
);
  import sgrt_pkg::*;

  status_t              mem_status [MAX_RESULTS];
  logic [ADDR_BITS-1:0] mem_phys   [MAX_RESULTS];
  logic [LEN_W-1:0]     mem_len    [MAX_RESULTS];

  logic                 busy_r;
  logic [SEG_CNT_W-1:0] cnt_r;
  logic [SEG_IDX_W-1:0] rd_r;
  logic                 wr_flag_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [ADDR_BITS-1:0] out_phys_r;
  logic [LEN_W-1:0]     out_len_r;
  logic                 out_wr_r;
  logic                 out_last_r;
  logic                 load;
  logic                 rd_last;

  assign load    = busy_r && (!out_valid_r || !out_stall);
  assign rd_last = SEG_CNT_W'(rd_r) == (cnt_r - SEG_CNT_W'(1));

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_status[ctl.idx] <= ctl.status;
      mem_phys[ctl.idx]   <= wr_phys;
      mem_len[ctl.idx]    <= wr_len;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= mem_status[rd_r];
      out_phys_r   <= mem_phys[rd_r];
      out_len_r    <= mem_len[rd_r];
      out_wr_r     <= wr_flag_r;
      out_last_r   <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      rd_r        <= '0;
      wr_flag_r   <= 1'b0;
    end else begin
      if (ctl.commit && (ctl.cnt != '0)) begin
        busy_r    <= 1'b1;
        cnt_r     <= ctl.cnt;
        rd_r      <= '0;
        wr_flag_r <= ctl.is_write;
      end else if (load) begin
        rd_r <= rd_r + SEG_IDX_W'(1);
        if (rd_last) begin
          busy_r <= 1'b0;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_phys_addr  = out_phys_r;
  assign out_seg_length = out_len_r;
  assign out_is_write   = out_wr_r;
  assign out_last       = out_last_r;

endmodule

// ----- sv/scatter_gather_region_translator.sv -----
// ----------------------------------------------------------------------------
// scatter_gather_region_translator
// region table with request splitting into physical segments
// ----------------------------------------------------------------------------
// Usage: commands enter on the in_ channel (begin, add, finish, read, write).
// Each accepted command except the unused codes yields one or more results
// on the out_ channel; out_last marks the final one of a command.
// Begin, add, finish, a zero-length read or write and every refused request
// give one result, written into the result buffer, then registered at its
// output. A read or write sends a cursor down a row of table cells, one cell
// per cycle, up to the last cell that covers the request; the segments it
// cuts are written into the buffer and, once the walk ends, played out one
// per cycle while out_ is not stalled, through the single read port of the
// result buffer.
// A new command is taken once the previous results have all left the
// buffer; the last of them may still sit in the output register.
// A stall on out_ holds the output register and, through the buffer, the
// input. Reset empties the table, clears the ready flag and drops any
// pending results; table entries themselves hold no reset value.
// ----------------------------------------------------------------------------
module scatter_gather_region_translator #(
  parameter int MAX_ENTRIES = sgrt_pkg::DEF_MAX_ENTRIES,
  parameter int ADDR_BITS   = sgrt_pkg::DEF_ADDR_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sgrt_pkg::CMD_W-1:0]  in_cmd,
  input  logic [ADDR_BITS-1:0]        in_region_start,
  input  logic [sgrt_pkg::SECT_W-1:0] in_region_sectors,
  input  logic [sgrt_pkg::LEN_W-1:0]  in_offset,
  input  logic [sgrt_pkg::LEN_W-1:0]  in_byte_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic [ADDR_BITS-1:0]        out_phys_addr,
  output logic [sgrt_pkg::LEN_W-1:0]  out_seg_length,
  output logic                        out_is_write,
  output logic                        out_last
);
  import sgrt_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_ENTRIES - 1);

  localparam logic [CMD_W-1:0] CMD_BEGIN  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd4;

  typedef enum logic {IDLE, WALK} state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     entry_count_r, entry_count_nxt;
  logic [LEN_W-1:0]     running_total_r, running_total_nxt;
  logic [LEN_W-1:0]     expected_total_r, expected_total_nxt;
  logic                 list_ready_r, list_ready_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [SEG_CNT_W-1:0] nseg_r, nseg_nxt;
  logic                 wr_flag_r, wr_flag_nxt;

  logic                 in_acc;
  logic                 buf_busy;
  logic [LEN_W-1:0]     add_bytes;
  logic [LEN_W-1:0]     add_end;
  logic                 add_ovf;
  logic                 add_wr;
  logic [LEN_W:0]       req_end;
  logic                 req_range;
  logic                 flush;
  logic                 single;
  status_t              single_st;
  logic                 single_wr;
  buf_ctl_t             bctl;
  logic [ADDR_BITS-1:0] wr_phys;
  logic [LEN_W-1:0]     wr_len;
  logic [ADDR_BITS-1:0] add_smb;

  token_t               tok_chain [MAX_ENTRIES];
  token_t               tok_tail;
  cell_stat_t           cell_stat [MAX_ENTRIES];
  logic [ADDR_BITS-1:0] cell_phys [MAX_ENTRIES];
  logic [LEN_W-1:0]     cell_len  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_wr;
  logic [MAX_ENTRIES-1:0] cell_busy;
  token_t               inject;
  cell_stat_t           sel_stat;

  assign in_stall  = !((state_r == IDLE) && !buf_busy);
  assign in_acc    = in_valid && !in_stall;
  assign add_bytes = LEN_W'(in_region_sectors) << SECTOR_SHIFT;
  assign add_end   = running_total_r + add_bytes;
  assign add_ovf   = add_bytes > ~running_total_r;
  assign add_smb   = in_region_start - ADDR_BITS'(running_total_r);
  assign req_end   = {1'b0, in_offset} + {1'b0, in_byte_count};
  assign req_range = req_end > {1'b0, expected_total_r};
  assign sel_stat  = cell_stat[pos_r];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign cell_wr[i]   = add_wr && (entry_count_r == CNT_W'(i));
    assign cell_busy[i] = cell_stat[i].busy;
    if (i == 0) begin : g_head
      assign tok_chain[i] = inject;
    end
    if (i == MAX_ENTRIES - 1) begin : g_end
      sgrt_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cell_wr[i]),
        .wr_smb  (add_smb),
        .wr_base (running_total_r),
        .wr_end  (add_end),
        .flush   (flush),
        .tok_in  (tok_chain[i]),
        .tok_out (tok_tail),
        .stat    (cell_stat[i]),
        .seg_phys(cell_phys[i]),
        .seg_len (cell_len[i])
      );
    end else begin : g_mid
      sgrt_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cell_wr[i]),
        .wr_smb  (add_smb),
        .wr_base (running_total_r),
        .wr_end  (add_end),
        .flush   (flush),
        .tok_in  (tok_chain[i]),
        .tok_out (tok_chain[i+1]),
        .stat    (cell_stat[i]),
        .seg_phys(cell_phys[i]),
        .seg_len (cell_len[i])
      );
    end
  end

  always_comb begin
    state_nxt          = state_r;
    entry_count_nxt    = entry_count_r;
    running_total_nxt  = running_total_r;
    expected_total_nxt = expected_total_r;
    list_ready_nxt     = list_ready_r;
    pos_nxt            = pos_r;
    nseg_nxt           = nseg_r;
    wr_flag_nxt        = wr_flag_r;
    add_wr             = 1'b0;
    flush              = 1'b0;
    inject             = '0;
    single             = 1'b0;
    single_st          = ST_OK;
    single_wr          = 1'b0;
    bctl               = '0;
    bctl.status        = ST_OK;
    wr_phys            = '0;
    wr_len             = '0;

    unique case (state_r)
      IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_BEGIN: begin
              single             = 1'b1;
              entry_count_nxt    = '0;
              running_total_nxt  = '0;
              expected_total_nxt = in_byte_count;
              list_ready_nxt     = 1'b0;
            end
            CMD_ADD: begin
              single = 1'b1;
              if (entry_count_r >= CNT_W'(MAX_ENTRIES)) begin
                single_st = ST_FULL;
              end else if (add_ovf) begin
                single_st = ST_RANGE;
              end else begin
                add_wr            = 1'b1;
                entry_count_nxt   = entry_count_r + CNT_W'(1);
                running_total_nxt = add_end;
                list_ready_nxt    = 1'b0;
              end
            end
            CMD_FINISH: begin
              single = 1'b1;
              if (running_total_r == expected_total_r) begin
                list_ready_nxt = 1'b1;
              end else begin
                single_st = ST_MISMATCH;
              end
            end
            CMD_READ, CMD_WRITE: begin
              if (req_range) begin
                single    = 1'b1;
                single_st = ST_RANGE;
              end else if (!list_ready_r) begin
                single    = 1'b1;
                single_st = ST_NOT_READY;
              end else if (in_byte_count == '0) begin
                single    = 1'b1;
                single_wr = (in_cmd == CMD_WRITE);
              end else begin
                inject.valid = 1'b1;
                inject.off   = in_offset;
                inject.stop  = req_end[LEN_W-1:0];
                pos_nxt      = '0;
                nseg_nxt     = '0;
                wr_flag_nxt  = (in_cmd == CMD_WRITE);
                state_nxt    = WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      WALK: begin
        pos_nxt = pos_r + POS_W'(1);
        if (sel_stat.hit && (nseg_r == SEG_CNT_W'(MAX_RESULTS))) begin
          single    = 1'b1;
          single_st = ST_RANGE;
          flush     = 1'b1;
          state_nxt = IDLE;
        end else begin
          if (sel_stat.hit) begin
            bctl.wr_en  = 1'b1;
            bctl.idx    = nseg_r[SEG_IDX_W-1:0];
            bctl.status = ST_OK;
            wr_phys     = cell_phys[pos_r];
            wr_len      = cell_len[pos_r];
            nseg_nxt    = nseg_r + SEG_CNT_W'(1);
          end
          if (sel_stat.done || (pos_r == LAST_POS)) begin
            bctl.commit   = 1'b1;
            bctl.cnt      = nseg_nxt;
            bctl.is_write = wr_flag_r;
            flush         = 1'b1;
            state_nxt     = IDLE;
          end
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase

    if (single) begin
      bctl.wr_en    = 1'b1;
      bctl.idx      = '0;
      bctl.status   = single_st;
      bctl.commit   = 1'b1;
      bctl.cnt      = SEG_CNT_W'(1);
      bctl.is_write = single_wr;
      wr_phys       = '0;
      wr_len        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= IDLE;
      entry_count_r    <= '0;
      running_total_r  <= '0;
      expected_total_r <= '0;
      list_ready_r     <= 1'b0;
      pos_r            <= '0;
      nseg_r           <= '0;
      wr_flag_r        <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      entry_count_r    <= entry_count_nxt;
      running_total_r  <= running_total_nxt;
      expected_total_r <= expected_total_nxt;
      list_ready_r     <= list_ready_nxt;
      pos_r            <= pos_nxt;
      nseg_r           <= nseg_nxt;
      wr_flag_r        <= wr_flag_nxt;
    end
  end

  sgrt_seg_buf #(.ADDR_BITS(ADDR_BITS)) u_buf (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (bctl),
    .wr_phys       (wr_phys),
    .wr_len        (wr_len),
    .busy          (buf_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_phys_addr (out_phys_addr),
    .out_seg_length(out_seg_length),
    .out_is_write  (out_is_write),
    .out_last      (out_last)
  );

`ifndef SYNTHESIS
  a_one_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_busy))
    else $error("more than one cell holds the cursor");

  a_idle_no_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == IDLE) |-> ((cell_busy == '0) && !tok_tail.valid))
    else $error("cursor left in the cell row while idle");

  a_ready_total: assert property (@(posedge clk) disable iff (!rst_n)
    list_ready_r |-> (running_total_r == expected_total_r))
    else $error("list ready with mismatched totals");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count past table size");

  a_walk_buf_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == WALK) |-> !buf_busy)
    else $error("result buffer busy during walk");
`endif

endmodule
